// ===== design/btid_pkg.sv =====
// Shared types, constants and codes of the box / tent image downsampler.
`timescale 1ns / 1ps
package btid_pkg;
	localparam int MAX_SRC_W = 1024;
	localparam int MAX_FAC   = 16;
	localparam int HEIGHT_LIM = 1024;
	localparam int CNT_W  = 11;
	localparam int POS_W  = 10;
	localparam int FAC_W  = 5;
	localparam int SUB_W  = 4;
	localparam int TAP_W  = 6;
	localparam int TW_W   = 18;
	localparam int SMP_W  = 16;
	localparam int ACC_W  = 34;
	localparam int QB     = 17;
	localparam int NUM_W  = ACC_W + SMP_W;
	localparam int NCH    = 4;
	localparam int MEM_AW = POS_W + 1;
	localparam int MEM_D  = 2 * MAX_SRC_W;
	localparam int MEM_W  = NCH * ACC_W;

	localparam logic [SMP_W-1:0] MAX8  = 16'd255;
	localparam logic [SMP_W-1:0] MAX16 = 16'd65535;

	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_HFAC   = 3'd2;
	localparam logic [2:0] REG_VFAC   = 3'd3;
	localparam logic [2:0] REG_MODE   = 3'd4;
	localparam logic [2:0] REG_NCH    = 3'd5;
	localparam logic [2:0] REG_SWIDE  = 3'd6;
	localparam logic [2:0] REG_DWIDE  = 3'd7;

	typedef enum logic [3:0] {
		S_CLEAR, S_TOT_LOAD, S_TOT_SUM, S_TOT_SAVE, S_IDLE, S_TGT, S_WSUM,
		S_READ, S_MUL, S_ADD, S_POST, S_DLOAD, S_DSTEP, S_DSTORE, S_OUT
	} state_t;

	typedef struct packed {
		logic [CNT_W-1:0] width;
		logic [CNT_W-1:0] height;
		logic [FAC_W-1:0] hfac;
		logic [FAC_W-1:0] vfac;
		logic             tent;
		logic [2:0]       nch;
		logic             swide;
		logic             dwide;
	} cfg_t;

	typedef struct packed {
		logic       restart;
		logic       clr;
		logic       tot_load;
		logic       tap_step;
		logic       div_prep;
		logic       accept;
		logic       tgt_load;
		logic       mem_rd;
		logic       mul;
		logic       add;
		logic       adv;
		logic       div_load;
		logic       div_step;
		logic       div_store;
		logic [1:0] tgt;
		logic [1:0] ch;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic tap_last;
		logic tgt_valid;
		logic emit;
		logic div_last;
	} status_t;
endpackage

// ===== design/btid_dp.sv =====
// Datapath: position counters, tap weight unit, accumulator memory, divider, result registers.
`timescale 1ns / 1ps
module btid_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  btid_pkg::cfg_t   cfg,
	input  btid_pkg::cmd_t   cmd,
	output btid_pkg::status_t sts,
	input  logic [63:0]      in_data,
	output logic [63:0]      out_data,
	output logic             out_last
);
	import btid_pkg::*;

	logic [POS_W-1:0] c_q, cbase_q, x0_q, r_q, rbase_q;
	logic [SUB_W-1:0] cm_q, rm_q;
	logic             yp_q;
	logic [MEM_AW-1:0] clr_q;
	logic             emit_q, eoi_q;
	logic [4:0]       dcnt_q;

	logic signed [TAP_W-1:0] i_q, j_q, ilo_q, ihi_q, jhi_q;
	logic [TW_W-1:0]  wsum_q;
	logic [MEM_AW-1:0] addr_q;
	logic [ACC_W-1:0] divisor_q;
	logic [SMP_W-1:0] sample_q [NCH];
	logic [ACC_W-1:0] prod_q [NCH];
	logic [ACC_W-1:0] acc_q [NCH];
	logic [MEM_W-1:0] rd_q;
	logic [MEM_W-1:0] mem_q [MEM_D];
	logic [ACC_W-1:0] rem_q;
	logic [QB-1:0]    nlo_q, quo_q;
	logic [SMP_W-1:0] res_q [NCH];

	logic [SMP_W-1:0] dmax;
	logic [11:0] wext, hext, cend1, cend2, rend1, rend2;
	logic col0_ok, col1_ok, row0_ok, row1_ok, col_ok, row_ok;
	logic signed [TAP_W-1:0] sx_s, sy_s, cm_s, rm_s, ilo, ihi, jlo, jhi;
	logic [4:0] ai, aj, dx, dy;
	logic [9:0] wa, wb, tw;
	logic [TW_W-1:0] weight, total;
	logic [ACC_W-1:0] tot34, sum [NCH];
	logic [ACC_W-1:0] dacc;
	logic [NUM_W-1:0] num;
	logic [ACC_W:0] trial;
	logic quo_bit;
	logic emit_now, eoi_now;
	logic wr_en;
	logic [MEM_AW-1:0] wr_addr;
	logic [MEM_W-1:0] wr_data, sum_w;

	assign dmax = cfg.dwide ? MAX16 : MAX8;

	assign wext  = {1'b0, cfg.width};
	assign hext  = {1'b0, cfg.height};
	assign cend1 = {2'b00, cbase_q} + {7'b0, cfg.hfac};
	assign cend2 = cend1 + {7'b0, cfg.hfac};
	assign rend1 = {2'b00, rbase_q} + {7'b0, cfg.vfac};
	assign rend2 = rend1 + {7'b0, cfg.vfac};
	assign col0_ok = cend1 <= wext;
	assign col1_ok = (cm_q != '0) && (cend2 <= wext);
	assign row0_ok = rend1 <= hext;
	assign row1_ok = (rm_q != '0) && (rend2 <= hext);

	assign sx_s = signed'({1'b0, cfg.hfac});
	assign sy_s = signed'({1'b0, cfg.vfac});
	assign cm_s = signed'({2'b00, cm_q});
	assign rm_s = signed'({2'b00, rm_q});

	always_comb begin
		if (cmd.tgt[0]) begin
			col_ok = col1_ok;
			ilo = cm_s - sx_s;
			ihi = cm_s - sx_s;
		end else begin
			col_ok = col0_ok;
			ilo = (c_q == '0) ? (6'sd1 - sx_s) : cm_s;
			ihi = (c_q == '0) ? 6'sd0 : cm_s;
		end
		if (cmd.tgt[1]) begin
			row_ok = row1_ok;
			jlo = rm_s - sy_s;
			jhi = rm_s - sy_s;
		end else begin
			row_ok = row0_ok;
			jlo = (r_q == '0) ? (6'sd1 - sy_s) : rm_s;
			jhi = (r_q == '0) ? 6'sd0 : rm_s;
		end
	end

	assign emit_now = ({1'b0, cm_q} == cfg.hfac - 5'd1) && ({1'b0, rm_q} == cfg.vfac - 5'd1)
		&& col0_ok && row0_ok;
	assign eoi_now = emit_now && !(cend2 <= wext) && !(rend2 <= hext);

	assign sts.tgt_valid = cfg.tent ? (col_ok && row_ok)
		: ((cmd.tgt == 2'd0) && col0_ok && row0_ok);
	assign sts.tap_last  = (i_q == ihi_q) && (j_q == jhi_q);
	assign sts.clr_last  = clr_q == '1;
	assign sts.emit      = emit_q;
	assign sts.div_last  = dcnt_q == 5'(QB - 1);

	// tap weight min((sx-|i|)*sy, (sy-|j|)*sx)
	always_comb begin
		ai = i_q[TAP_W-1] ? 5'(-i_q) : i_q[4:0];
		aj = j_q[TAP_W-1] ? 5'(-j_q) : j_q[4:0];
		dx = cfg.hfac - ai;
		dy = cfg.vfac - aj;
		wa = {5'b0, dx} * {5'b0, cfg.vfac};
		wb = {5'b0, dy} * {5'b0, cfg.hfac};
		tw = (wa < wb) ? wa : wb;
	end

	assign weight = cfg.tent ? wsum_q : TW_W'(1);
	assign total  = cfg.tent ? wsum_q : {8'b0, 10'({5'b0, cfg.hfac} * {5'b0, cfg.vfac})};
	assign tot34  = {16'b0, total};

	always_comb begin
		for (int k = 0; k < NCH; k++) begin
			sum[k] = rd_q[k*ACC_W +: ACC_W] + prod_q[k];
			sum_w[k*ACC_W +: ACC_W] = sum[k];
		end
	end

	assign wr_en   = cmd.clr | cmd.add;
	assign wr_addr = cmd.clr ? clr_q : addr_q;
	assign wr_data = (cmd.clr || (emit_q && cmd.tgt == 2'd0)) ? '0 : sum_w;

	assign dacc = acc_q[cmd.ch];
	assign num  = cfg.dwide ? ({dacc, 16'b0} - {16'b0, dacc})
		: ({8'b0, dacc, 8'b0} - {16'b0, dacc});
	assign trial   = {rem_q, nlo_q[QB-1]};
	assign quo_bit = trial >= {1'b0, divisor_q};

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0; cm_q <= '0; cbase_q <= '0; x0_q <= '0;
			r_q <= '0; rm_q <= '0; rbase_q <= '0; yp_q <= 1'b0;
			clr_q <= '0; emit_q <= 1'b0; eoi_q <= 1'b0; dcnt_q <= '0;
		end else if (cmd.restart) begin
			c_q <= '0; cm_q <= '0; cbase_q <= '0; x0_q <= '0;
			r_q <= '0; rm_q <= '0; rbase_q <= '0; yp_q <= 1'b0;
			clr_q <= '0;
		end else begin
			if (cmd.clr)
				clr_q <= clr_q + 1'b1;
			if (cmd.accept) begin
				emit_q <= emit_now;
				eoi_q <= eoi_now;
			end
			if (cmd.div_load)
				dcnt_q <= '0;
			else if (cmd.div_step)
				dcnt_q <= dcnt_q + 1'b1;
			if (cmd.adv) begin
				if ({1'b0, c_q} + 11'd1 >= cfg.width) begin
					c_q <= '0; cm_q <= '0; cbase_q <= '0; x0_q <= '0;
					if ({1'b0, r_q} + 11'd1 >= cfg.height) begin
						r_q <= '0; rm_q <= '0; rbase_q <= '0; yp_q <= 1'b0;
					end else begin
						r_q <= r_q + 1'b1;
						if ({1'b0, rm_q} == cfg.vfac - 5'd1) begin
							rm_q <= '0;
							rbase_q <= rend1[POS_W-1:0];
							yp_q <= ~yp_q;
						end else begin
							rm_q <= rm_q + 1'b1;
						end
					end
				end else begin
					c_q <= c_q + 1'b1;
					if ({1'b0, cm_q} == cfg.hfac - 5'd1) begin
						cm_q <= '0;
						cbase_q <= cend1[POS_W-1:0];
						x0_q <= x0_q + 1'b1;
					end else begin
						cm_q <= cm_q + 1'b1;
					end
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.tot_load) begin
			ilo_q <= 6'sd1 - sx_s; ihi_q <= sx_s - 6'sd1;
			i_q <= 6'sd1 - sx_s; j_q <= 6'sd1 - sy_s; jhi_q <= sy_s - 6'sd1;
			wsum_q <= '0;
		end else if (cmd.tgt_load) begin
			ilo_q <= ilo; ihi_q <= ihi; i_q <= ilo; j_q <= jlo; jhi_q <= jhi;
			wsum_q <= '0;
			addr_q <= {yp_q ^ cmd.tgt[1], x0_q + {9'b0, cmd.tgt[0]}};
		end else if (cmd.tap_step) begin
			wsum_q <= wsum_q + {8'b0, tw};
			if (i_q == ihi_q) begin
				i_q <= ilo_q;
				j_q <= j_q + 6'sd1;
			end else begin
				i_q <= i_q + 6'sd1;
			end
		end
		if (cmd.div_prep)
			divisor_q <= cfg.swide ? ((tot34 << 16) - tot34) : ((tot34 << 8) - tot34);
		if (cmd.accept) begin
			for (int k = 0; k < NCH; k++) begin
				if (k == 0 || cfg.nch >= 3'd3)
					sample_q[k] <= cfg.swide ? in_data[k*SMP_W +: SMP_W]
						: {8'b0, in_data[k*SMP_W +: 8]};
				else
					sample_q[k] <= '0;
			end
		end
		if (cmd.mul)
			for (int k = 0; k < NCH; k++)
				prod_q[k] <= ACC_W'(sample_q[k]) * ACC_W'(weight);
		if (cmd.add && cmd.tgt == 2'd0)
			for (int k = 0; k < NCH; k++)
				acc_q[k] <= sum[k];
		if (cmd.div_load) begin
			rem_q <= {1'b0, num[NUM_W-1:QB]};
			nlo_q <= num[QB-1:0];
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= quo_bit ? ACC_W'(trial - {1'b0, divisor_q}) : trial[ACC_W-1:0];
			nlo_q <= {nlo_q[QB-2:0], 1'b0};
			quo_q <= {quo_q[QB-2:0], quo_bit};
		end
		if (cmd.div_store)
			res_q[cmd.ch] <= (quo_q > {1'b0, dmax}) ? dmax : quo_q[SMP_W-1:0];
	end

	// accumulator memory
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (cmd.mem_rd)
			rd_q <= mem_q[addr_q];
	end

	always_comb begin
		out_data = {48'b0, res_q[0]};
		if (cfg.nch >= 3'd3) begin
			out_data[31:16] = res_q[1];
			out_data[47:32] = res_q[2];
			out_data[63:48] = (cfg.nch == 3'd3) ? dmax : res_q[3];
		end
	end
	assign out_last = eoi_q;
endmodule

// ===== design/btid_ctrl.sv =====
// Controller state machine sequencing clear, weight, accumulate and divide steps.
`timescale 1ns / 1ps
module btid_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              restart,
	input  logic              tent,
	input  btid_pkg::status_t sts,
	output btid_pkg::cmd_t    cmd,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready
);
	import btid_pkg::*;

	state_t state_q, state_d;
	logic [1:0] t_q, ch_q;
	logic t_clr, t_inc, ch_clr, ch_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			t_q <= '0;
			ch_q <= '0;
		end else begin
			state_q <= state_d;
			if (t_clr)
				t_q <= '0;
			else if (t_inc)
				t_q <= t_q + 1'b1;
			if (ch_clr)
				ch_q <= '0;
			else if (ch_inc)
				ch_q <= ch_q + 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:    if (sts.clr_last) state_d = S_TOT_LOAD;
			S_TOT_LOAD: state_d = S_TOT_SUM;
			S_TOT_SUM:  if (sts.tap_last) state_d = S_TOT_SAVE;
			S_TOT_SAVE: state_d = S_IDLE;
			S_IDLE:     if (s_tvalid) state_d = S_TGT;
			S_TGT: begin
				if (sts.tgt_valid)
					state_d = tent ? S_WSUM : S_READ;
				else if (t_q == 2'd3)
					state_d = S_POST;
			end
			S_WSUM:     if (sts.tap_last) state_d = S_READ;
			S_READ:     state_d = S_MUL;
			S_MUL:      state_d = S_ADD;
			S_ADD:      state_d = (t_q == 2'd3) ? S_POST : S_TGT;
			S_POST:     state_d = sts.emit ? S_DLOAD : S_IDLE;
			S_DLOAD:    state_d = S_DSTEP;
			S_DSTEP:    if (sts.div_last) state_d = S_DSTORE;
			S_DSTORE:   state_d = (ch_q == 2'd3) ? S_OUT : S_DLOAD;
			S_OUT:      if (m_tready) state_d = S_IDLE;
			default:    state_d = S_CLEAR;
		endcase
		if (restart)
			state_d = S_CLEAR;
	end

	always_comb begin
		cmd = '0;
		cmd.restart = restart;
		cmd.tgt = t_q;
		cmd.ch = ch_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		t_clr = 1'b0;
		t_inc = 1'b0;
		ch_clr = 1'b0;
		ch_inc = 1'b0;
		unique case (state_q)
			S_CLEAR:    cmd.clr = ~restart;
			S_TOT_LOAD: cmd.tot_load = 1'b1;
			S_TOT_SUM:  cmd.tap_step = 1'b1;
			S_TOT_SAVE: cmd.div_prep = 1'b1;
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.accept = s_tvalid;
				t_clr = 1'b1;
			end
			S_TGT: begin
				if (sts.tgt_valid)
					cmd.tgt_load = 1'b1;
				else
					t_inc = 1'b1;
			end
			S_WSUM:     cmd.tap_step = 1'b1;
			S_READ:     cmd.mem_rd = 1'b1;
			S_MUL:      cmd.mul = 1'b1;
			S_ADD: begin
				cmd.add = 1'b1;
				t_inc = 1'b1;
			end
			S_POST: begin
				cmd.adv = 1'b1;
				ch_clr = 1'b1;
			end
			S_DLOAD:    cmd.div_load = 1'b1;
			S_DSTEP:    cmd.div_step = 1'b1;
			S_DSTORE: begin
				cmd.div_store = 1'b1;
				ch_inc = 1'b1;
			end
			S_OUT:      m_tvalid = 1'b1;
			default:    cmd.clr = 1'b0;
		endcase
	end
endmodule

// ===== design/box_triangle_image_downsampler.sv =====
// Top level: configuration registers and stream ports of the box / tent image downsampler.
// Per source pixel, each accumulator touched (up to four) is read, added to and written back
// and, in tent mode, first has its weight summed over its taps (up to 256 at pixel (0,0)).
// A pixel that completes an output pixel then runs the shared 17-step divider over all four
// channels. One pixel is in work at a time; a new one is taken only in the idle state.
// Reset and each config write clear all 2048 accumulators, then total (2sx-1)(2sy-1) tap weights.
`timescale 1ns / 1ps
module box_triangle_image_downsampler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // in_red, in_green, in_blue, in_alpha
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // out_red, out_green, out_blue, out_alpha
	output logic        m_tlast,   // end_of_image
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data
);
	import btid_pkg::*;

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t sts;
	logic    cfg_wr;
	logic [FAC_W-1:0] fac_c;
	logic [2:0] nch_c;
	logic [CNT_W-1:0] dim_c;
	logic [CNT_W-1:0] hgt_c;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid & cfg_ready;

	always_comb begin
		dim_c = (cfg_data == '0) ? CNT_W'(1)
			: ((cfg_data > CNT_W'(MAX_SRC_W)) ? CNT_W'(MAX_SRC_W) : cfg_data);
		hgt_c = (cfg_data == '0) ? CNT_W'(1)
			: ((cfg_data > CNT_W'(HEIGHT_LIM)) ? CNT_W'(HEIGHT_LIM) : cfg_data);
		fac_c = (cfg_data[4:0] == '0) ? FAC_W'(1)
			: ((cfg_data[4:0] > FAC_W'(MAX_FAC)) ? FAC_W'(MAX_FAC) : cfg_data[4:0]);
		nch_c = (cfg_data[2:0] == '0) ? 3'd1 : ((cfg_data[2:0] > 3'd4) ? 3'd4 : cfg_data[2:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= CNT_W'(MAX_SRC_W);
			cfg_q.height <= CNT_W'(HEIGHT_LIM);
			cfg_q.hfac   <= FAC_W'(2);
			cfg_q.vfac   <= FAC_W'(2);
			cfg_q.tent   <= 1'b0;
			cfg_q.nch    <= 3'd4;
			cfg_q.swide  <= 1'b0;
			cfg_q.dwide  <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_WIDTH:  cfg_q.width  <= dim_c;
				REG_HEIGHT: cfg_q.height <= hgt_c;
				REG_HFAC:   cfg_q.hfac   <= fac_c;
				REG_VFAC:   cfg_q.vfac   <= fac_c;
				REG_MODE:   cfg_q.tent   <= cfg_data[0];
				REG_NCH:    cfg_q.nch    <= nch_c;
				REG_SWIDE:  cfg_q.swide  <= cfg_data[0];
				REG_DWIDE:  cfg_q.dwide  <= cfg_data[0];
				default:    cfg_q.dwide  <= cfg_q.dwide;
			endcase
		end
	end

	btid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (cfg_wr),
		.tent     (cfg_q.tent),
		.sts      (sts),
		.cmd      (cmd),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	btid_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (s_tdata),
		.out_data (m_tdata),
		.out_last (m_tlast)
	);
endmodule
